// File: hdl/ccmf_pkg.sv
// ----------------------------------------------------------------------------
// ccmf_pkg
// Shared types, constants and the CRC-8 step for the measurement frame
// receiver.
// ----------------------------------------------------------------------------
package ccmf_pkg;

   localparam int unsigned NumWords  = 8;
   localparam int unsigned WordIdxW  = $clog2(NumWords);
   localparam logic [7:0]  CrcInit   = 8'hFF;
   localparam logic [7:0]  CrcPoly   = 8'h31;
   localparam logic [WordIdxW-1:0] LastWord = WordIdxW'(NumWords - 1);

   typedef enum logic [1:0] {
      SUB_HIGH = 2'd0,
      SUB_LOW  = 2'd1,
      SUB_CRC  = 2'd2
   } sub_type;

   typedef struct packed {
      logic [15:0]        pm1;
      logic [15:0]        pm2_5;
      logic [15:0]        pm4;
      logic [15:0]        pm10;
      logic signed [15:0] humidity;
      logic signed [15:0] temperature;
      logic signed [15:0] voc_index;
      logic signed [15:0] nox_index;
      logic               frame_ok;
   } result_type;

   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CrcPoly;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// File: hdl/ccmf_if.sv
// ----------------------------------------------------------------------------
// ccmf_if
// Request and response channels of the measurement frame receiver.
// ----------------------------------------------------------------------------
interface ccmf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_start;

   modport source (output valid, output data_byte, output frame_start, input ready);
   modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface ccmf_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        pm1;
   logic [15:0]        pm2_5;
   logic [15:0]        pm4;
   logic [15:0]        pm10;
   logic signed [15:0] humidity;
   logic signed [15:0] temperature;
   logic signed [15:0] voc_index;
   logic signed [15:0] nox_index;
   logic               frame_ok;

   modport source (output valid, output pm1, output pm2_5, output pm4, output pm10,
                   output humidity, output temperature, output voc_index,
                   output nox_index, output frame_ok, input ready);
   modport sink   (input valid, input pm1, input pm2_5, input pm4, input pm10,
                   input humidity, input temperature, input voc_index,
                   input nox_index, input frame_ok, output ready);
endinterface

// File: hdl/ccmf_assembler.sv
// ----------------------------------------------------------------------------
// ccmf_assembler
// Tracks the byte position, checks each word's CRC-8 and stores the eight
// words of the frame; flags the final byte with the completed result.
// ----------------------------------------------------------------------------
module ccmf_assembler import ccmf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic [7:0] data_byte,
   input  logic       frame_start,
   output logic       at_last,
   output logic       res_valid,
   output result_type result
);

   logic [WordIdxW-1:0] word_ff, word_in, cur_word;
   sub_type             sub_ff, sub_in, cur_sub;
   logic [7:0]          high_ff, high_in;
   logic [7:0]          crc_ff, crc_in, crc_calc;
   logic                err_ff, err_in, err_base;
   logic [15:0]         words_ff [NumWords];
   logic                word_we;

   always_comb begin
      cur_word = frame_start ? '0 : word_ff;
      cur_sub  = frame_start ? SUB_HIGH : sub_ff;
      crc_calc = crc8_byte((cur_sub == SUB_HIGH) ? CrcInit : crc_ff, data_byte);
      err_base = (cur_word == '0 && cur_sub == SUB_HIGH) ? 1'b0 : err_ff;
   end

   always_comb begin
      high_in = high_ff;
      crc_in  = crc_ff;
      err_in  = err_base;
      word_we = 1'b0;
      word_in = cur_word;
      sub_in  = cur_sub;
      unique case (cur_sub)
         SUB_HIGH: begin
            crc_in  = crc_calc;
            high_in = data_byte;
            sub_in  = SUB_LOW;
         end
         SUB_LOW: begin
            crc_in  = crc_calc;
            word_we = 1'b1;
            sub_in  = SUB_CRC;
         end
         SUB_CRC: begin
            err_in  = err_base | (crc_ff != data_byte);
            crc_in  = CrcInit;
            sub_in  = SUB_HIGH;
            word_in = cur_word + 1'b1;
         end
         default: begin
            sub_in  = SUB_HIGH;
            word_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff <= '0;
         sub_ff  <= SUB_HIGH;
         high_ff <= '0;
         crc_ff  <= CrcInit;
         err_ff  <= 1'b0;
      end else if (fire) begin
         word_ff <= word_in;
         sub_ff  <= sub_in;
         high_ff <= high_in;
         crc_ff  <= crc_in;
         err_ff  <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && word_we) begin
         words_ff[cur_word] <= {high_ff, data_byte};
      end
   end

   assign at_last   = (word_ff == LastWord) && (sub_ff == SUB_CRC);
   assign res_valid = fire && (cur_word == LastWord) && (cur_sub == SUB_CRC);

   always_comb begin
      result.pm1         = words_ff[0];
      result.pm2_5       = words_ff[1];
      result.pm4         = words_ff[2];
      result.pm10        = words_ff[3];
      result.humidity    = words_ff[4];
      result.temperature = words_ff[5];
      result.voc_index   = words_ff[6];
      result.nox_index   = words_ff[7];
      result.frame_ok    = !err_in;
   end

   a_start_restarts: assert property (@(posedge clock) disable iff (reset)
      fire && frame_start |=> word_ff == '0 && sub_ff == SUB_LOW)
      else $error("frame start did not restart the position");

   a_crc_reinit: assert property (@(posedge clock) disable iff (reset)
      sub_ff == SUB_HIGH |-> crc_ff == CrcInit)
      else $error("word CRC not reinitialized at word boundary");

endmodule

// File: hdl/crc_checked_measurement_frame.sv
// ----------------------------------------------------------------------------
// crc_checked_measurement_frame
// Receives the 24-byte measurement frame, checks the CRC-8 of each word and
// returns the eight raw values with a frame_ok flag.
// ----------------------------------------------------------------------------
// One request byte is taken every cycle. The frame is eight words of high
// byte, low byte and CRC-8 (poly 0x31, init 0xFF); frame_start restarts at
// byte 0. The response appears in the cycle after the last byte of a frame
// is accepted and sits in an output register until taken. The request side
// stalls only when the last byte of the next frame is due while that
// response is still waiting; all other bytes keep flowing.
module crc_checked_measurement_frame import ccmf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   ccmf_req_if.sink   req_bus,
   ccmf_rsp_if.source rsp_bus
);

   logic       req_fire, at_last, res_valid;
   result_type result;
   result_type rsp_data_ff;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_bus.ready = !(rsp_valid_ff && !rsp_bus.ready && at_last);
   assign req_fire      = req_bus.valid && req_bus.ready;

   ccmf_assembler u_assembler (
      .clock       (clock),
      .reset       (reset),
      .fire        (req_fire),
      .data_byte   (req_bus.data_byte),
      .frame_start (req_bus.frame_start),
      .at_last     (at_last),
      .res_valid   (res_valid),
      .result      (result)
   );

   assign rsp_valid_in = res_valid || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.pm1         = rsp_data_ff.pm1;
   assign rsp_bus.pm2_5       = rsp_data_ff.pm2_5;
   assign rsp_bus.pm4         = rsp_data_ff.pm4;
   assign rsp_bus.pm10        = rsp_data_ff.pm10;
   assign rsp_bus.humidity    = rsp_data_ff.humidity;
   assign rsp_bus.temperature = rsp_data_ff.temperature;
   assign rsp_bus.voc_index   = rsp_data_ff.voc_index;
   assign rsp_bus.nox_index   = rsp_data_ff.nox_index;
   assign rsp_bus.frame_ok    = rsp_data_ff.frame_ok;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_bus.ready |-> !res_valid)
      else $error("pending response overwritten");

   a_rise_from_last: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff ##1 rsp_valid_ff |-> $past(res_valid))
      else $error("response without a completed frame");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_bus.ready && !res_valid |=> !rsp_valid_ff)
      else $error("response repeated after being taken");

endmodule
